>>> sv/fbfl_pkg.sv
package fbfl_pkg;

	localparam int unsigned LINK_W          = 8;
	localparam int unsigned LINK_DEPTH      = 256;
	localparam int unsigned SIZE_W          = 13;
	localparam int unsigned OFFSET_W        = 12;
	localparam int unsigned COUNT_W         = 9;
	localparam int unsigned ACC_W           = 21;
	localparam int unsigned PROD_W          = LINK_W + SIZE_W;
	localparam int unsigned PAGE_BYTES_DEF  = 4096;
	localparam int unsigned MIN_BLOCK_DEF   = 16;
	localparam int unsigned MAX_BLOCK_BYTES = 4096;
	localparam int unsigned RESET_BLOCK     = 16;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_POP
	} state_t;

	typedef struct packed {
		logic              en;
		logic [LINK_W-1:0] addr;
		logic [LINK_W-1:0] data;
	} link_wr_t;

	typedef struct packed {
		logic               busy;
		logic [COUNT_W-1:0] block_total;
		logic [SIZE_W-1:0]  blk_bytes;
	} sweep_stat_t;

	function automatic logic [SIZE_W-1:0] clamp_size(logic [SIZE_W-1:0] v,
		int unsigned min_b);
		logic [SIZE_W-1:0] s;
		s = v;
		if (s < SIZE_W'(min_b)) s = SIZE_W'(min_b);
		if (s > SIZE_W'(MAX_BLOCK_BYTES)) s = SIZE_W'(MAX_BLOCK_BYTES);
		return s;
	endfunction

endpackage

>>> sv/fbfl_if.sv
interface fbfl_item_if;
	logic                        valid;
	logic                        ready;
	logic                        opcode;
	logic [fbfl_pkg::LINK_W-1:0] block_index;

	modport source (output valid, opcode, block_index, input ready);
	modport sink   (input valid, opcode, block_index, output ready);
endinterface

interface fbfl_result_if;
	logic                          valid;
	logic                          ready;
	logic                          granted;
	logic [fbfl_pkg::LINK_W-1:0]   given_index;
	logic [fbfl_pkg::OFFSET_W-1:0] given_offset;
	logic [fbfl_pkg::COUNT_W-1:0]  blocks_free;

	modport source (output valid, granted, given_index, given_offset, blocks_free,
		input ready);
	modport sink   (input valid, granted, given_index, given_offset, blocks_free,
		output ready);
endinterface

interface fbfl_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [fbfl_pkg::SIZE_W-1:0] blk_bytes;

	modport source (output valid, blk_bytes, input ready);
	modport sink   (input valid, blk_bytes, output ready);
endinterface

>>> sv/fixed_block_free_list_allocator.sv
// Fixed-size block pool: a page of PAGE_BYTES is cut into blocks of blk_bytes bytes
// (clamped to MIN_BLOCK_BYTES..4096, at most 256 blocks) whose free indices are chained
// through a 256-entry next-link RAM with a head register and a free count. Every request
// transaction yields exactly one response transaction. A release or failed allocate leaves
// the controller ready for the next request; a granted allocate goes through ST_POP,
// reading the new head from the synchronous link RAM before the next request is taken.
// After reset and after every blk_bytes write the list is rebuilt in ascending order by
// a pass over all 256 link RAM entries (one a cycle, restarted by any new write), then
// a count reload in ST_SWEEP; no request is taken meanwhile, blk_bytes writes always are.
module fixed_block_free_list_allocator #(
	parameter int unsigned PAGE_BYTES      = fbfl_pkg::PAGE_BYTES_DEF,
	parameter int unsigned MIN_BLOCK_BYTES = fbfl_pkg::MIN_BLOCK_DEF
) (
	input logic           clk,
	input logic           arst_n,
	fbfl_cfg_if.sink      cfg,
	fbfl_item_if.sink     req,
	fbfl_result_if.source rsp
);

	fbfl_pkg::sweep_stat_t       stat;
	fbfl_pkg::link_wr_t          sweep_wr;
	fbfl_pkg::link_wr_t          ctrl_wr;
	fbfl_pkg::link_wr_t          ram_wr;
	logic [fbfl_pkg::LINK_W-1:0] rd_addr;
	logic [fbfl_pkg::LINK_W-1:0] rd_data;

	fbfl_sweep #(
		.PAGE_BYTES      (PAGE_BYTES),
		.MIN_BLOCK_BYTES (MIN_BLOCK_BYTES)
	) u_sweep (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.wr     (sweep_wr),
		.stat   (stat)
	);

	fbfl_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.stat    (stat),
		.rd_data (rd_data),
		.rd_addr (rd_addr),
		.wr      (ctrl_wr)
	);

	assign ram_wr = sweep_wr.en ? sweep_wr : ctrl_wr;

	fbfl_ram #(
		.WIDTH (fbfl_pkg::LINK_W),
		.DEPTH (fbfl_pkg::LINK_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_wr.en),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

endmodule

>>> sv/fbfl_ram.sv
module fbfl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

>>> sv/fbfl_sweep.sv
module fbfl_sweep #(
	parameter int unsigned PAGE_BYTES      = fbfl_pkg::PAGE_BYTES_DEF,
	parameter int unsigned MIN_BLOCK_BYTES = fbfl_pkg::MIN_BLOCK_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	fbfl_cfg_if.sink              cfg,
	output fbfl_pkg::link_wr_t    wr,
	output fbfl_pkg::sweep_stat_t stat
);

	localparam logic [fbfl_pkg::SIZE_W-1:0] RESET_SIZE =
		fbfl_pkg::clamp_size(fbfl_pkg::SIZE_W'(fbfl_pkg::RESET_BLOCK), MIN_BLOCK_BYTES);
	localparam logic [fbfl_pkg::ACC_W-1:0] PAGE_LIMIT = fbfl_pkg::ACC_W'(PAGE_BYTES);

	logic                           busy_q;
	logic [fbfl_pkg::LINK_W-1:0]    idx_q;
	logic [fbfl_pkg::ACC_W-1:0]     acc_q;
	logic [fbfl_pkg::ACC_W-1:0]     acc_next;
	logic [fbfl_pkg::COUNT_W-1:0]   total_q;
	logic [fbfl_pkg::SIZE_W-1:0]    size_q;
	logic [fbfl_pkg::SIZE_W-1:0]    size_new;
	logic                           cfg_fire;

	assign cfg.ready = 1'b1;
	assign cfg_fire  = cfg.valid;
	assign size_new  = fbfl_pkg::clamp_size(cfg.blk_bytes, MIN_BLOCK_BYTES);
	assign acc_next  = acc_q + fbfl_pkg::ACC_W'(size_q);

	always_comb begin
		wr.en   = busy_q;
		wr.addr = idx_q;
		wr.data = ((acc_next <= PAGE_LIMIT) && (idx_q != '1))
			? idx_q + fbfl_pkg::LINK_W'(1) : '0;
	end

	assign stat.busy        = busy_q;
	assign stat.block_total = total_q;
	assign stat.blk_bytes   = size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b1;
			idx_q   <= '0;
			acc_q   <= fbfl_pkg::ACC_W'(RESET_SIZE);
			total_q <= '0;
			size_q  <= RESET_SIZE;
		end else if (cfg_fire) begin
			busy_q  <= 1'b1;
			idx_q   <= '0;
			acc_q   <= fbfl_pkg::ACC_W'(size_new);
			total_q <= '0;
			size_q  <= size_new;
		end else if (busy_q) begin
			if (acc_q <= PAGE_LIMIT) total_q <= total_q + fbfl_pkg::COUNT_W'(1);
			idx_q <= idx_q + fbfl_pkg::LINK_W'(1);
			acc_q <= acc_next;
			if (idx_q == '1) busy_q <= 1'b0;
		end
	end

endmodule

>>> sv/fbfl_ctrl.sv
module fbfl_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	fbfl_item_if.sink                   req,
	fbfl_result_if.source               rsp,
	input  fbfl_pkg::sweep_stat_t       stat,
	input  logic [fbfl_pkg::LINK_W-1:0] rd_data,
	output logic [fbfl_pkg::LINK_W-1:0] rd_addr,
	output fbfl_pkg::link_wr_t          wr
);

	fbfl_pkg::state_t state_q, state_d;

	logic [fbfl_pkg::LINK_W-1:0]   head_q, head_d;
	logic [fbfl_pkg::COUNT_W-1:0]  free_q, free_d;
	logic                          out_valid_q;
	logic                          granted_q;
	logic [fbfl_pkg::LINK_W-1:0]   index_q;
	logic [fbfl_pkg::OFFSET_W-1:0] offset_q;
	logic [fbfl_pkg::COUNT_W-1:0]  count_q;
	logic                          fire, pop, push, out_free;
	logic [fbfl_pkg::PROD_W-1:0]   prod;

	assign prod     = fbfl_pkg::PROD_W'(head_q) * fbfl_pkg::PROD_W'(stat.blk_bytes);
	assign out_free = !out_valid_q || rsp.ready;
	assign fire     = req.valid && req.ready;
	assign pop      = fire && (req.opcode == fbfl_pkg::OP_ALLOC) && (free_q != '0);
	assign push     = fire && (req.opcode == fbfl_pkg::OP_FREE);
	assign rd_addr  = head_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fbfl_pkg::ST_SWEEP: begin
				if (!stat.busy) state_d = fbfl_pkg::ST_IDLE;
			end
			fbfl_pkg::ST_IDLE: begin
				if (stat.busy) state_d = fbfl_pkg::ST_SWEEP;
				else if (pop) state_d = fbfl_pkg::ST_POP;
			end
			fbfl_pkg::ST_POP: begin
				state_d = stat.busy ? fbfl_pkg::ST_SWEEP : fbfl_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req.ready = (state_q == fbfl_pkg::ST_IDLE) && !stat.busy && out_free;
		wr.en     = push;
		wr.addr   = req.block_index;
		wr.data   = head_q;
		head_d    = head_q;
		free_d    = free_q;
		unique case (state_q)
			fbfl_pkg::ST_SWEEP: begin
				head_d = '0;
				free_d = stat.block_total;
			end
			fbfl_pkg::ST_IDLE: begin
				if (pop) free_d = free_q - fbfl_pkg::COUNT_W'(1);
				if (push) begin
					head_d = req.block_index;
					if (free_q < stat.block_total) free_d = free_q + fbfl_pkg::COUNT_W'(1);
				end
			end
			fbfl_pkg::ST_POP: begin
				head_d = rd_data;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fbfl_pkg::ST_SWEEP;
			head_q      <= '0;
			free_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			free_q  <= free_d;
			if (fire) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			granted_q <= pop || push;
			index_q   <= pop ? head_q : '0;
			offset_q  <= pop ? prod[fbfl_pkg::OFFSET_W-1:0] : '0;
			count_q   <= free_d;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.granted      = granted_q;
	assign rsp.given_index  = index_q;
	assign rsp.given_offset = offset_q;
	assign rsp.blocks_free  = count_q;

endmodule

>>> sv/fbfl_checker.sv
module fbfl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic                          rsp_granted,
	input logic [fbfl_pkg::LINK_W-1:0]   rsp_given_index,
	input logic [fbfl_pkg::OFFSET_W-1:0] rsp_given_offset,
	input logic [fbfl_pkg::COUNT_W-1:0]  rsp_blocks_free
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("no response after request transaction");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_granted |-> rsp_given_index == '0 && rsp_given_offset == '0
			&& rsp_blocks_free == '0)
		else $error("failed allocate with nonzero fields");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_blocks_free <= fbfl_pkg::COUNT_W'(fbfl_pkg::LINK_DEPTH))
		else $error("free count beyond pool depth");

	a_rebuild_block: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !req_ready)
		else $error("request taken during rebuild");

endmodule

bind fixed_block_free_list_allocator fbfl_checker u_fbfl_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.cfg_valid        (cfg.valid),
	.cfg_ready        (cfg.ready),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_granted      (rsp.granted),
	.rsp_given_index  (rsp.given_index),
	.rsp_given_offset (rsp.given_offset),
	.rsp_blocks_free  (rsp.blocks_free)
);
